FILE: hw/rtl/button_long_press_enable_window_core_macros.svh
// Assertion macros for the button long-press enable window core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef BUTTON_LONG_PRESS_ENABLE_WINDOW_CORE_MACROS_SVH
`define BUTTON_LONG_PRESS_ENABLE_WINDOW_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BLEW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blew assertion failed");
// next-cycle implication
`define BLEW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blew assertion failed");
`else
`define BLEW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BLEW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/blew_pkg.sv
// Shared types and constants for the button long-press enable window core.
// Used by blew_engine and button_long_press_enable_window_core; no dependencies.
package blew_pkg;

  // default width of the saturating age and elapsed-time counters
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // register indexes
  localparam logic [2:0] CFG_DEFAULT_WINDOW = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS     = 3'd1;
  localparam logic [2:0] CFG_REBOOT_PRESS   = 3'd2;
  localparam logic [2:0] CFG_DEBOUNCE       = 3'd3;
  localparam logic [2:0] CFG_COOLDOWN       = 3'd4;

  // register reset values
  localparam logic [31:0] RST_DEFAULT_WINDOW = 32'd180000;
  localparam logic [15:0] RST_LONG_PRESS     = 16'd3000;
  localparam logic [15:0] RST_REBOOT_PRESS   = 16'd10000;
  localparam logic [9:0]  RST_DEBOUNCE       = 10'd50;
  localparam logic [15:0] RST_COOLDOWN       = 16'd500;

  // request actions
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_ENABLE  = 2'd1;
  localparam logic [1:0] ACT_DISABLE = 2'd2;

  // event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ACTIVATED = 3'd1;
  localparam logic [2:0] EV_FAILED    = 3'd2;
  localparam logic [2:0] EV_TIMEOUT   = 3'd3;
  localparam logic [2:0] EV_DISABLED  = 3'd4;
  localparam logic [2:0] EV_REBOOT    = 3'd5;

  // reported press phase codes
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_PRESSED = 2'd1;
  localparam logic [1:0] PHASE_LONG    = 2'd2;

  // press machine state, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PRESSED = 3'b010,
    PH_LONG    = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        button_level;
    logic [31:0] duration_ms;
    logic        with_feedback;
    logic        radio_ready;
  } item_t;

  typedef struct packed {
    logic        link_enabled;
    logic [31:0] remaining_ms;
    logic [2:0]  event_res;
    logic        feedback_on;
    logic        button_held;
    logic [1:0]  press_phase;
  } result_t;

  typedef struct packed {
    logic        wr;
    logic [2:0]  index;
    logic [31:0] wdata;
  } cfg_wr_t;

endpackage

FILE: hw/rtl/blew_engine.sv
// Configuration registers, button/window state and the single-pass step logic.
// Depends on blew_pkg.
module blew_engine import blew_pkg::*; #(
  parameter int unsigned TimeWidth = TIME_WIDTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

  // compare width covering both the time counters and 32-bit lengths
  localparam int unsigned CmpWidth = (TimeWidth > 32) ? TimeWidth : 32;

  logic [31:0] default_window_q;
  logic [15:0] long_press_q;
  logic [15:0] reboot_press_q;
  logic [9:0]  debounce_q;
  logic [15:0] cooldown_ms_q;

  logic                 deb_q, deb_d;
  logic                 prev_q, prev_d;
  logic [TimeWidth-1:0] age_q, age_d;
  logic [15:0]          cool_q, cool_d;
  phase_e               phase_q, phase_d;
  logic [15:0]          held_q, held_d;
  logic                 open_q, open_d;
  logic [31:0]          len_q, len_d;
  logic [TimeWidth-1:0] elapsed_q, elapsed_d;
  logic                 fb_q, fb_d;
  logic [2:0]           ev;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_window_q <= RST_DEFAULT_WINDOW;
      long_press_q     <= RST_LONG_PRESS;
      reboot_press_q   <= RST_REBOOT_PRESS;
      debounce_q       <= RST_DEBOUNCE;
      cooldown_ms_q    <= RST_COOLDOWN;
    end else if (cfg_i.wr) begin
      unique case (cfg_i.index)
        CFG_DEFAULT_WINDOW: default_window_q <= cfg_i.wdata;
        CFG_LONG_PRESS:     long_press_q     <= cfg_i.wdata[15:0];
        CFG_REBOOT_PRESS:   reboot_press_q   <= cfg_i.wdata[15:0];
        CFG_DEBOUNCE:       debounce_q       <= cfg_i.wdata[9:0];
        CFG_COOLDOWN:       cooldown_ms_q    <= cfg_i.wdata[15:0];
        default: ;
      endcase
    end
  end

  // step logic: one request in, next state and result out
  always_comb begin
    logic [TimeWidth-1:0] age_snap;
    logic                 frozen;
    logic                 pressed;
    logic                 do_open;
    logic                 reboot;
    logic [31:0]          open_dur;
    logic                 open_fb;
    logic [CmpWidth-1:0]  len_w;
    logic [CmpWidth-1:0]  el_w;
    logic [CmpWidth-1:0]  diff_w;

    deb_d     = deb_q;
    prev_d    = prev_q;
    age_d     = age_q;
    cool_d    = cool_q;
    phase_d   = phase_q;
    held_d    = held_q;
    open_d    = open_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    fb_d      = fb_q;
    ev        = EV_NONE;
    age_snap  = '0;
    frozen    = 1'b0;
    pressed   = 1'b0;
    do_open   = 1'b0;
    reboot    = 1'b0;
    open_dur  = item_i.duration_ms;
    open_fb   = item_i.with_feedback;

    unique case (item_i.action)
      ACT_TICK: begin
        // saturating time counters
        if (age_d != '1) age_d = age_d + 1'b1;
        if (phase_q != PH_IDLE && held_d != 16'hFFFF) held_d = held_d + 16'd1;
        if (open_q && elapsed_d != '1) elapsed_d = elapsed_d + 1'b1;

        // cooldown masks the button and freezes the debouncer
        if (cool_d != 16'd0) begin
          cool_d = cool_d - 16'd1;
          if (cool_d != 16'd0) frozen = 1'b1;
        end

        // leading-edge debouncer with lockout
        if (!frozen) begin
          age_snap = age_d;
          if (item_i.button_level != prev_d) age_d = '0;
          if (age_snap > TimeWidth'(debounce_q)) deb_d = item_i.button_level;
          prev_d  = item_i.button_level;
          pressed = !deb_d;
        end

        // press machine
        unique case (phase_q)
          PH_PRESSED: begin
            if (!pressed) begin
              phase_d = PH_IDLE;
              cool_d  = cooldown_ms_q;
            end else if (held_d >= reboot_press_q) begin
              reboot = 1'b1;
            end else if (held_d >= long_press_q) begin
              phase_d  = PH_LONG;
              do_open  = 1'b1;
              open_dur = 32'd0;
              open_fb  = 1'b1;
            end
          end
          PH_LONG: begin
            if (!pressed) phase_d = PH_IDLE;
            else if (held_d >= reboot_press_q) reboot = 1'b1;
          end
          default: begin
            if (pressed) begin
              phase_d = PH_PRESSED;
              held_d  = 16'd0;
            end
          end
        endcase
      end
      ACT_ENABLE: do_open = 1'b1;
      ACT_DISABLE: begin
        if (open_q) begin
          open_d = 1'b0;
          fb_d   = 1'b0;
          ev     = EV_DISABLED;
        end
      end
      default: ;
    endcase

    // window (re)start
    if (do_open) begin
      len_d     = (open_dur == 32'd0) ? default_window_q : open_dur;
      elapsed_d = '0;
      if (!item_i.radio_ready) begin
        open_d = 1'b0;
        fb_d   = 1'b0;
        ev     = EV_FAILED;
      end else begin
        open_d = 1'b1;
        fb_d   = open_fb;
        ev     = EV_ACTIVATED;
      end
    end

    // reboot wins; otherwise check the window timeout on a tick
    if (reboot) begin
      deb_d     = 1'b1;
      prev_d    = 1'b1;
      age_d     = '1;
      cool_d    = 16'd0;
      phase_d   = PH_IDLE;
      held_d    = 16'd0;
      open_d    = 1'b0;
      len_d     = 32'd0;
      elapsed_d = '0;
      fb_d      = 1'b0;
      ev        = EV_REBOOT;
    end else if (item_i.action == ACT_TICK && open_d &&
                 CmpWidth'(elapsed_d) >= CmpWidth'(len_d)) begin
      open_d = 1'b0;
      fb_d   = 1'b0;
      ev     = EV_TIMEOUT;
    end

    // result from the updated state
    len_w  = CmpWidth'(len_d);
    el_w   = CmpWidth'(elapsed_d);
    diff_w = len_w - el_w;
    res_o.link_enabled = open_d;
    res_o.remaining_ms = (open_d && el_w < len_w) ? diff_w[31:0] : 32'd0;
    res_o.event_res    = ev;
    res_o.feedback_on  = fb_d & open_d;
    res_o.button_held  = (cool_d == 16'd0) && !deb_d;
    unique case (phase_d)
      PH_PRESSED: res_o.press_phase = PHASE_PRESSED;
      PH_LONG:    res_o.press_phase = PHASE_LONG;
      default:    res_o.press_phase = PHASE_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= 1'b1;
      prev_q    <= 1'b1;
      age_q     <= '1;
      cool_q    <= 16'd0;
      phase_q   <= PH_IDLE;
      held_q    <= 16'd0;
      open_q    <= 1'b0;
      len_q     <= 32'd0;
      elapsed_q <= '0;
      fb_q      <= 1'b0;
    end else if (step_i) begin
      deb_q     <= deb_d;
      prev_q    <= prev_d;
      age_q     <= age_d;
      cool_q    <= cool_d;
      phase_q   <= phase_d;
      held_q    <= held_d;
      open_q    <= open_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
      fb_q      <= fb_d;
    end
  end

endmodule

FILE: hw/rtl/button_long_press_enable_window_core.sv
// Top level of the button long-press enable window core: handshakes and registers.
// Depends on blew_pkg, blew_engine and the assertion macro header.
//
// One request (millisecond tick, enable or soft disable) is accepted per clock cycle
// while in_ready_o is high and gives exactly one result. A request is held in an
// input register, passed through the single-pass step logic in blew_engine and
// captured in the result register once that register can take it. The input side
// keeps accepting while a result waits to be taken, until both registers are full.
// Configuration writes are always ready and take effect the next cycle; write
// them only while no request is in flight.
`include "button_long_press_enable_window_core_macros.svh"

module button_long_press_enable_window_core import blew_pkg::*; #(
  parameter int unsigned TimeWidth = TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        button_level_i,
  input  logic [31:0] duration_ms_i,
  input  logic        with_feedback_i,
  input  logic        radio_ready_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        link_enabled_o,
  output logic [31:0] remaining_ms_o,
  output logic [2:0]  event_res_o,
  output logic        feedback_on_o,
  output logic        button_held_o,
  output logic [1:0]  press_phase_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    res_take;
  logic    step;
  cfg_wr_t cfg_wr;

  // pipeline flow control
  assign res_take   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && res_take;
  assign in_ready_o = !s1_valid_q || res_take;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.wr    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.wdata = cfg_wdata_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q.action        <= action_i;
      s1_item_q.button_level  <= button_level_i;
      s1_item_q.duration_ms   <= duration_ms_i;
      s1_item_q.with_feedback <= with_feedback_i;
      s1_item_q.radio_ready   <= radio_ready_i;
    end
  end

  blew_engine #(
    .TimeWidth(TimeWidth)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_wr),
    .step_i(step),
    .item_i(s1_item_q),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign link_enabled_o = res_q.link_enabled;
  assign remaining_ms_o = res_q.remaining_ms;
  assign event_res_o    = res_q.event_res;
  assign feedback_on_o  = res_q.feedback_on;
  assign button_held_o  = res_q.button_held;
  assign press_phase_o  = res_q.press_phase;

  // checks
  `BLEW_ASSERT_IMP(a_fb_needs_link, clk_i, rst_ni, out_valid_q && res_q.feedback_on, res_q.link_enabled)
  `BLEW_ASSERT_IMP(a_closed_no_time, clk_i, rst_ni, out_valid_q && !res_q.link_enabled, res_q.remaining_ms == 32'd0)
  `BLEW_ASSERT_IMP(a_reboot_clean, clk_i, rst_ni, out_valid_q && res_q.event_res == EV_REBOOT, !res_q.link_enabled && !res_q.button_held && res_q.press_phase == PHASE_IDLE)
  `BLEW_ASSERT_IMP(a_activated_open, clk_i, rst_ni, out_valid_q && res_q.event_res == EV_ACTIVATED, res_q.link_enabled)
  `BLEW_ASSERT_NXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !res_take, s1_valid_q && $stable(s1_item_q))

endmodule
